// ===== sv/pesfh_pkg.sv =====
// Shared types, constants and byte functions for the path edge fingerprint hash.
// No dependencies; imported by pesfh_accum and the top level.
package pesfh_pkg;

  // Default depth of the path buffer in bytes.
  localparam int unsigned MaxPathLenDef = 256;

  // Extension patterns: the first four lowercased extension bytes, first byte lowest.
  localparam logic [31:0] MagicKf  = 32'h00666B2E;
  localparam logic [31:0] MagicNif = 32'h66696E2E;
  localparam logic [31:0] MagicDds = 32'h7364642E;
  localparam logic [31:0] MagicWav = 32'h7661772E;

  // Marks OR-ed into the low word for a matching extension.
  localparam logic [31:0] MarkKf  = 32'h00000080;
  localparam logic [31:0] MarkNif = 32'h00008000;
  localparam logic [31:0] MarkDds = 32'h00008080;
  localparam logic [31:0] MarkWav = 32'h80000000;

  localparam logic [7:0] DotChar = 8'h2E;

  // Role of one stored byte during the sweep over the path.
  typedef struct packed {
    logic       first;      // first name byte, bits 24-31
    logic       name_last;  // last name byte, bits 0-7
    logic       name_prev;  // byte before the last name byte, bits 8-15
    logic       name_sum;   // enters the name sdbm sum
    logic       ext_sum;    // enters the extension sdbm sum
    logic       magic;      // one of the first four extension bytes
    logic [1:0] magic_sel;  // its byte lane in the pattern word
  } byte_role_t;

  // Lowercase ASCII A-Z only.
  function automatic logic [7:0] fold_case(input logic [7:0] b);
    logic [7:0] r;
    r = b;
    if (b >= 8'h41 && b <= 8'h5A) begin
      r = b + 8'h20;
    end
    return r;
  endfunction

  // One sdbm step: b + acc * 65599, mod 2^32.
  function automatic logic [31:0] sdbm_step(input logic [31:0] acc, input logic [7:0] b);
    return {24'h0, b} + (acc << 6) + (acc << 16) - acc;
  endfunction

endpackage

// ===== sv/pesfh_mem.sv =====
// Path byte buffer: synchronous memory, one write port and one read port.
// Read data is registered. Depends on nothing but its parameters.
module pesfh_mem #(
  parameter int unsigned Depth = 256,
  parameter int unsigned AddrW = 8
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AddrW-1:0] wr_addr_i,
  input  logic [7:0]       wr_data_i,
  input  logic             rd_en_i,
  input  logic [AddrW-1:0] rd_addr_i,
  output logic [7:0]       rd_data_o
);

  logic [7:0] mem_q [Depth];
  logic [7:0] rd_data_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== sv/pesfh_accum.sv =====
// Per-byte datapath of the sweep: packs the fingerprint bytes, gathers the
// extension pattern and runs the two sdbm sums. Uses pesfh_pkg.
module pesfh_accum
  import pesfh_pkg::*;
(
  input  logic        clk_i,
  input  logic        clr_i,
  input  logic        vld_i,
  input  byte_role_t  role_i,
  input  logic [7:0]  byte_i,
  output logic [63:0] hash_o
);

  logic [31:0] low_q, low_d;
  logic [31:0] magic_q, magic_d;
  logic [31:0] name_sum_q, name_sum_d;
  logic [31:0] ext_sum_q, ext_sum_d;
  logic [7:0]  fb;
  logic [31:0] mark;

  assign fb = fold_case(byte_i);

  // Fold one byte into whichever fields its role selects.
  always_comb begin
    low_d      = low_q;
    magic_d    = magic_q;
    name_sum_d = name_sum_q;
    ext_sum_d  = ext_sum_q;
    if (clr_i) begin
      low_d      = '0;
      magic_d    = '0;
      name_sum_d = '0;
      ext_sum_d  = '0;
    end else if (vld_i) begin
      if (role_i.first)     low_d = low_d | {fb, 24'h0};
      if (role_i.name_last) low_d = low_d | {24'h0, fb};
      if (role_i.name_prev) low_d = low_d | {16'h0, fb, 8'h0};
      if (role_i.magic) begin
        magic_d = magic_q | ({24'h0, fb} << {role_i.magic_sel, 3'b000});
      end
      if (role_i.name_sum) name_sum_d = sdbm_step(name_sum_q, fb);
      if (role_i.ext_sum)  ext_sum_d  = sdbm_step(ext_sum_q, fb);
    end
  end

  always_ff @(posedge clk_i) begin
    low_q      <= low_d;
    magic_q    <= magic_d;
    name_sum_q <= name_sum_d;
    ext_sum_q  <= ext_sum_d;
  end

  // Extension mark from the gathered pattern; short extensions are zero padded.
  always_comb begin
    if (magic_q == MagicKf) begin
      mark = MarkKf;
    end else if (magic_q == MagicNif) begin
      mark = MarkNif;
    end else if (magic_q == MagicDds) begin
      mark = MarkDds;
    end else if (magic_q == MagicWav) begin
      mark = MarkWav;
    end else begin
      mark = '0;
    end
  end

  // Both sums land at bit 32, so only the high word sees them.
  assign hash_o = {name_sum_q + ext_sum_q, low_q | mark};

endmodule

// ===== sv/path_edge_sdbm_fingerprint_hash.sv =====
// Top level of the path edge fingerprint hash: control sequencer, path buffer
// and sweep datapath. Uses pesfh_pkg, pesfh_mem and pesfh_accum.
//
//  Channel  Direction  Signals                  Contents
//  s_axis   in         tvalid/tready/tdata/tlast  tdata[7:0] path_byte, tlast final_byte
//  m_axis   out        tvalid/tready/tdata/tuser  tdata[63:0] hash_value, tuser too_long
//
// Each accepted path byte up to the buffer depth is stored. After the last byte the block reads
// the stored path back through the buffer's single read port, one byte a cycle.
// An overflowed path or an empty name skips the read pass and gives a zero hash.
// Input stays stalled during the read pass; the output register lets the next
// path load while a result still waits. Reset clears all control state.
module path_edge_sdbm_fingerprint_hash
  import pesfh_pkg::*;
#(
  parameter int unsigned MAX_PATH_LEN = MaxPathLenDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] path_byte
  input  logic        s_axis_tlast_i,   // final_byte
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [63:0] m_axis_tdata_o,   // [63:0] hash_value
  output logic        m_axis_tuser_o    // [0] too_long
);

  localparam int unsigned AW = $clog2(MAX_PATH_LEN);
  localparam int unsigned CW = AW + 1;
  localparam logic [CW-1:0] MaxLen = CW'(MAX_PATH_LEN);

  localparam logic [1:0] StLoad   = 2'd0;
  localparam logic [1:0] StPrep   = 2'd1;
  localparam logic [1:0] StSweep  = 2'd2;
  localparam logic [1:0] StFinish = 2'd3;

  logic [1:0]    state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] dot_pos_q, dot_pos_d;
  logic          dot_seen_q, dot_seen_d;
  logic          ovf_q, ovf_d;
  logic          zero_q, zero_d;
  logic          too_long_q, too_long_d;
  logic [CW-1:0] name_len_q, name_len_d;
  logic [CW-1:0] rd_addr_q, rd_addr_d;
  logic          rd_vld_q, rd_vld_d;
  logic [AW-1:0] rd_idx_q, rd_idx_d;
  logic          m_valid_q, m_valid_d;
  logic [63:0]   m_data_q, m_data_d;
  logic          m_user_q, m_user_d;

  logic          in_fire;
  logic          wr_en;
  logic          rd_en;
  logic          acc_clr;
  logic [7:0]    rd_data;
  logic [63:0]   acc_hash;
  logic [31:0]   name_len32;
  logic [CW:0]   ix;
  logic [CW:0]   nl;
  logic [CW:0]   ext_off;
  byte_role_t    role;

  assign s_axis_tready_o = (state_q == StLoad);
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;
  assign wr_en           = in_fire && (count_q < MaxLen);
  assign rd_en           = (state_q == StSweep) && (rd_addr_q < count_q);
  assign acc_clr         = (state_q == StPrep);
  assign name_len32      = 32'(name_len_q);

  // Writes happen only while loading and reads only while sweeping, so the
  // two ports never touch the buffer in the same cycle.
  pesfh_mem #(
    .Depth (MAX_PATH_LEN),
    .AddrW (AW)
  ) u_mem (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (count_q[AW-1:0]),
    .wr_data_i (s_axis_tdata_i),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr_q[AW-1:0]),
    .rd_data_o (rd_data)
  );

  // Role of the byte returning from the buffer, by its position in the path.
  always_comb begin
    ix      = {1'b0, CW'(rd_idx_q)};
    nl      = {1'b0, name_len_q};
    ext_off = ix - nl;
    role.first     = (ix == '0);
    role.name_last = (ix + 1'b1 == nl);
    role.name_prev = (nl > (CW+1)'(2)) && (ix + (CW+1)'(2) == nl);
    role.name_sum  = (ix != '0) && (ix + (CW+1)'(2) < nl);
    role.ext_sum   = (ix >= nl);
    role.magic     = (ix >= nl) && (ext_off < (CW+1)'(4));
    role.magic_sel = ext_off[1:0];
  end

  pesfh_accum u_accum (
    .clk_i  (clk_i),
    .clr_i  (acc_clr),
    .vld_i  (rd_vld_q),
    .role_i (role),
    .byte_i (rd_data),
    .hash_o (acc_hash)
  );

  // Sequencer: load bytes, set up the sweep, walk the buffer, hand off the result.
  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    dot_pos_d  = dot_pos_q;
    dot_seen_d = dot_seen_q;
    ovf_d      = ovf_q;
    zero_d     = zero_q;
    too_long_d = too_long_q;
    name_len_d = name_len_q;
    rd_addr_d  = rd_addr_q;
    rd_vld_d   = 1'b0;
    rd_idx_d   = rd_idx_q;
    m_valid_d  = m_valid_q;
    m_data_d   = m_data_q;
    m_user_d   = m_user_q;

    if (m_valid_q && m_axis_tready_i) begin
      m_valid_d = 1'b0;
    end

    case (state_q)
      StLoad: begin
        if (in_fire) begin
          if (count_q < MaxLen) begin
            if (s_axis_tdata_i == DotChar) begin
              dot_pos_d  = count_q;
              dot_seen_d = 1'b1;
            end
            count_d = count_q + 1'b1;
          end else begin
            ovf_d = 1'b1;
          end
          if (s_axis_tlast_i) begin
            if (ovf_q || (count_q == MaxLen)) begin
              zero_d     = 1'b1;
              too_long_d = 1'b1;
              state_d    = StFinish;
            end else begin
              state_d = StPrep;
            end
          end
        end
      end
      StPrep: begin
        name_len_d = dot_seen_q ? dot_pos_q : count_q;
        rd_addr_d  = '0;
        if (name_len_d == '0) begin
          zero_d  = 1'b1;
          state_d = StFinish;
        end else begin
          state_d = StSweep;
        end
      end
      StSweep: begin
        if (rd_en) begin
          rd_vld_d  = 1'b1;
          rd_idx_d  = rd_addr_q[AW-1:0];
          rd_addr_d = rd_addr_q + 1'b1;
        end else if (!rd_vld_q) begin
          state_d = StFinish;
        end
      end
      StFinish: begin
        if (!m_valid_q || m_axis_tready_i) begin
          m_valid_d = 1'b1;
          m_user_d  = too_long_q;
          if (zero_q) begin
            m_data_d = '0;
          end else begin
            m_data_d = acc_hash | {32'h0, name_len32[15:0], 16'h0};
          end
          count_d    = '0;
          dot_pos_d  = '0;
          dot_seen_d = 1'b0;
          ovf_d      = 1'b0;
          zero_d     = 1'b0;
          too_long_d = 1'b0;
          state_d    = StLoad;
        end
      end
      default: begin
        state_d = StLoad;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StLoad;
      count_q    <= '0;
      dot_pos_q  <= '0;
      dot_seen_q <= 1'b0;
      ovf_q      <= 1'b0;
      zero_q     <= 1'b0;
      too_long_q <= 1'b0;
      rd_addr_q  <= '0;
      rd_vld_q   <= 1'b0;
      m_valid_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      count_q    <= count_d;
      dot_pos_q  <= dot_pos_d;
      dot_seen_q <= dot_seen_d;
      ovf_q      <= ovf_d;
      zero_q     <= zero_d;
      too_long_q <= too_long_d;
      rd_addr_q  <= rd_addr_d;
      rd_vld_q   <= rd_vld_d;
      m_valid_q  <= m_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    name_len_q <= name_len_d;
    rd_idx_q   <= rd_idx_d;
    m_data_q   <= m_data_d;
    m_user_q   <= m_user_d;
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;
  assign m_axis_tuser_o  = m_user_q;

  // The byte count never passes the buffer depth.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= MaxLen)
    else $error("byte count beyond buffer depth");

  // A recorded dot always lies inside the stored path.
  a_dot_inside: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dot_seen_q |-> (dot_pos_q < count_q))
    else $error("dot position outside stored path");

  // The read pass never runs past the stored bytes.
  a_sweep_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StSweep) |-> (rd_addr_q <= count_q))
    else $error("read address past stored path");

  // An overflowed path always reports a zero hash.
  a_too_long_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && m_user_q) |-> (m_data_q == '0))
    else $error("too-long result with nonzero hash");

endmodule
